/* rtl/arpr_pkg.sv */
// Package for the ARP request responder: payload and descriptor types,
// protocol constants and the reply byte selector. No dependencies.
`timescale 1ns / 1ps

package arpr_pkg;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_LOCAL_MAC = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOCAL_IP  = 1'd1;
  localparam int unsigned CFG_DATA_W = 48;

  // Protocol constants
  localparam logic [47:0] BCAST_MAC      = 48'hFFFF_FFFF_FFFF;
  localparam logic [15:0] ETYPE_ARP      = 16'h0806;
  localparam logic [15:0] ETYPE_IPV4     = 16'h0800;
  localparam logic [15:0] HW_ETHER       = 16'h0001;
  localparam logic [15:0] OPC_REQUEST    = 16'h0001;
  localparam logic [15:0] OPC_REPLY      = 16'h0002;
  localparam logic [7:0]  MAC_LEN        = 8'd6;
  localparam logic [7:0]  IP_LEN         = 8'd4;
  localparam logic [31:0] LOCAL_IP_RESET = 32'hC0A8_79DC;

  // Frame geometry
  localparam int unsigned POS_W     = 6;
  localparam logic [POS_W-1:0] POS_MAX  = 6'd63;
  localparam logic [POS_W-1:0] LAST_IDX = 6'd41;  // final byte of a minimal ARP frame
  localparam int unsigned RPL_BITS  = 336;         // 42 bytes

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } arpr_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
  } arpr_out_t;

  // What the back end needs to build one reply
  typedef struct packed {
    logic [47:0] sender_hw;
    logic [31:0] sender_proto;
  } rpl_desc_t;

  // Pick reply byte idx (0 = first on the wire)
  function automatic logic [7:0] reply_byte(input logic [POS_W-1:0] idx,
                                            input rpl_desc_t     desc,
                                            input logic [47:0]   mac,
                                            input logic [31:0]   ip);
    logic [RPL_BITS-1:0] frame;
    frame = {desc.sender_hw, mac, ETYPE_ARP, HW_ETHER, ETYPE_IPV4, MAC_LEN, IP_LEN,
             OPC_REPLY, mac, ip, desc.sender_hw, desc.sender_proto};
    return frame[RPL_BITS - 1 - 8 * int'(idx) -: 8];
  endfunction

endpackage

/* rtl/arpr_parse.sv */
// Front end: takes frame bytes, captures header fields by position and
// queues a reply descriptor for each matching ARP request. Uses arpr_pkg.
`timescale 1ns / 1ps

module arpr_parse (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  arpr_pkg::arpr_in_t  in_data_i,
  input  logic [47:0]         local_mac_i,
  input  logic [31:0]         local_ip_i,
  output logic                push_o,
  output arpr_pkg::rpl_desc_t push_data_o,
  input  logic                full_i
);

  logic [arpr_pkg::POS_W-1:0] pos_q, pos_d;
  logic [47:0] dst_q, dst_d;
  logic [15:0] type_q, type_d;
  logic [15:0] opc_q, opc_d;
  logic [47:0] sha_q, sha_d;
  logic [31:0] spa_q, spa_d;
  logic [31:0] tpa_q, tpa_d;
  logic        accept;
  logic        match;
  logic [7:0]  b;

  assign in_stall_o = full_i;
  assign accept     = in_valid_i && !full_i;
  assign b          = in_data_i.in_byte;

  // Shift the byte into the field that owns this position
  always_comb begin
    dst_d  = dst_q;
    type_d = type_q;
    opc_d  = opc_q;
    sha_d  = sha_q;
    spa_d  = spa_q;
    tpa_d  = tpa_q;
    if (pos_q < 6'd6) begin
      dst_d = {dst_q[39:0], b};
    end else if (pos_q == 6'd12 || pos_q == 6'd13) begin
      type_d = {type_q[7:0], b};
    end else if (pos_q == 6'd20 || pos_q == 6'd21) begin
      opc_d = {opc_q[7:0], b};
    end else if (pos_q >= 6'd22 && pos_q < 6'd28) begin
      sha_d = {sha_q[39:0], b};
    end else if (pos_q >= 6'd28 && pos_q < 6'd32) begin
      spa_d = {spa_q[23:0], b};
    end else if (pos_q >= 6'd38 && pos_q < 6'd42) begin
      tpa_d = {tpa_q[23:0], b};
    end
  end

  // Advance the position, saturate on long frames, restart after the last byte
  always_comb begin
    pos_d = pos_q;
    if (in_data_i.in_last) begin
      pos_d = '0;
    end else if (pos_q < arpr_pkg::POS_MAX) begin
      pos_d = pos_q + 6'd1;
    end
  end

  // Check the request against the fields including this byte
  assign match = (pos_q >= arpr_pkg::LAST_IDX) &&
                 (dst_d == local_mac_i || dst_d == arpr_pkg::BCAST_MAC) &&
                 (type_d == arpr_pkg::ETYPE_ARP) &&
                 (opc_d == arpr_pkg::OPC_REQUEST) &&
                 (tpa_d == local_ip_i);

  assign push_o                   = accept && in_data_i.in_last && match;
  assign push_data_o.sender_hw    = sha_d;
  assign push_data_o.sender_proto = spa_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      dst_q  <= '0;
      type_q <= '0;
      opc_q  <= '0;
      sha_q  <= '0;
      spa_q  <= '0;
      tpa_q  <= '0;
    end else if (accept) begin
      pos_q  <= pos_d;
      dst_q  <= dst_d;
      type_q <= type_d;
      opc_q  <= opc_d;
      sha_q  <= sha_d;
      spa_q  <= spa_d;
      tpa_q  <= tpa_d;
    end
  end

endmodule

/* rtl/arpr_queue.sv */
// Two-entry descriptor queue between the parser and the reply generator.
// Uses arpr_pkg for the descriptor type.
`timescale 1ns / 1ps

module arpr_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  arpr_pkg::rpl_desc_t push_data_i,
  output logic                full_o,
  input  logic                pop_i,
  output logic                valid_o,
  output arpr_pkg::rpl_desc_t pop_data_o
);

  localparam logic [1:0] DEPTH = 2'd2;

  arpr_pkg::rpl_desc_t mem_q [2];
  logic       wr_ptr_q;
  logic       rd_ptr_q;
  logic [1:0] cnt_q;

  assign full_o     = (cnt_q == DEPTH);
  assign valid_o    = (cnt_q != 2'd0);
  assign pop_data_o = mem_q[rd_ptr_q];

  // Store entries
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= DEPTH) else $error("queue count beyond depth");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> cnt_q != 2'd0) else $error("pop from empty queue");

endmodule

/* rtl/arpr_reply.sv */
// Back end: takes reply descriptors from the queue and sends the 42-byte
// ARP reply through a registered output word. Uses arpr_pkg.
`timescale 1ns / 1ps

module arpr_reply (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_valid_i,
  input  arpr_pkg::rpl_desc_t q_data_i,
  output logic                pop_o,
  input  logic [47:0]         local_mac_i,
  input  logic [31:0]         local_ip_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output arpr_pkg::arpr_out_t out_data_o
);

  arpr_pkg::rpl_desc_t        cur_q;
  logic                       busy_q;
  logic [arpr_pkg::POS_W-1:0] idx_q;
  logic                       o_valid_q;
  arpr_pkg::arpr_out_t        o_data_q, o_data_d;
  logic                       load_out;
  logic                       emit;
  logic                       at_end;

  assign load_out = !o_valid_q || !out_stall_i;
  assign emit     = busy_q && load_out;
  assign at_end   = (idx_q == arpr_pkg::LAST_IDX);
  assign pop_o    = !busy_q && q_valid_i;

  assign o_data_d.out_byte = arpr_pkg::reply_byte(idx_q, cur_q, local_mac_i, local_ip_i);
  assign o_data_d.out_last = at_end;

  assign out_valid_o = o_valid_q;
  assign out_data_o  = o_data_q;

  // Hold the current descriptor
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cur_q <= q_data_i;
    end
  end

  // Load the output word
  always_ff @(posedge clk_i) begin
    if (emit) begin
      o_data_q <= o_data_d;
    end
  end

  // Sequence the reply bytes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b0;
      idx_q     <= '0;
      o_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        busy_q <= 1'b1;
        idx_q  <= '0;
      end else if (emit) begin
        idx_q <= idx_q + 6'd1;
        if (at_end) begin
          busy_q <= 1'b0;
        end
      end
      if (load_out) begin
        o_valid_q <= emit;
      end
    end
  end

  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> idx_q <= arpr_pkg::LAST_IDX) else $error("reply index out of range");
  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (o_valid_q && o_data_q.out_last) |-> !busy_q || idx_q == '0)
    else $error("reply still running after final byte");
  a_start_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy_q) |-> idx_q == '0) else $error("reply did not start at byte zero");

endmodule

/* rtl/arp_request_responder_core.sv */
// ARP request responder top level: configuration registers, parser front
// end, descriptor queue and reply back end. Uses arpr_pkg.
`timescale 1ns / 1ps

// Usage:
//   Input channel (in_valid_i / in_stall_o / in_data_i) carries received
//   Ethernet frame bytes in wire order, in_last set on the final byte.
//   One byte is taken every cycle while in_stall_o is low; in_stall_o rises only while two reply
//   descriptors are already queued.
//   Output channel (out_valid_o / out_stall_i / out_data_o) carries the
//   42-byte ARP reply, out_last set on byte 42.
//   With the back end idle, an accepted request's descriptor passes the
//   queue and the back end's descriptor register before its first byte is
//   loaded into the output word; the reply streams one byte per cycle unless
//   stalled, and the next descriptor is popped only after the reply's last byte.
//   When the receiver stalls, the current output word holds and the reply
//   pauses; the parser keeps taking bytes until the queue fills.
//   Configuration (cfg_we_i, cfg_idx_i, cfg_data_i): index 0 writes the
//   local MAC, index 1 the local IP. Write only while idle.
//   Reset: local MAC clears, local IP returns to 192.168.121.220, the
//   parser restarts at frame byte 0 and the queue and output empty.

module arp_request_responder_core (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  arpr_pkg::arpr_in_t                   in_data_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output arpr_pkg::arpr_out_t                  out_data_o,
  input  logic                                 cfg_we_i,
  input  logic [arpr_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [arpr_pkg::CFG_DATA_W-1:0]      cfg_data_i
);

  logic [47:0]         local_mac_q;
  logic [31:0]         local_ip_q;
  logic                push;
  arpr_pkg::rpl_desc_t push_data;
  logic                full;
  logic                pop;
  logic                q_valid;
  arpr_pkg::rpl_desc_t q_data;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      local_mac_q <= '0;
      local_ip_q  <= arpr_pkg::LOCAL_IP_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        arpr_pkg::REG_LOCAL_MAC: local_mac_q <= cfg_data_i[47:0];
        arpr_pkg::REG_LOCAL_IP:  local_ip_q  <= cfg_data_i[31:0];
        default: ;
      endcase
    end
  end

  arpr_parse u_parse (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .local_mac_i (local_mac_q),
    .local_ip_i  (local_ip_q),
    .push_o      (push),
    .push_data_o (push_data),
    .full_i      (full)
  );

  arpr_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .valid_o     (q_valid),
    .pop_data_o  (q_data)
  );

  arpr_reply u_reply (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_data_i    (q_data),
    .pop_o       (pop),
    .local_mac_i (local_mac_q),
    .local_ip_i  (local_ip_q),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
